### rtl/core/sjfbs_pkg.sv
// Shared types and constants for the shortest-job-first burst scheduler.
// No dependencies; used by every module under rtl/core.
package sjfbs_pkg;

    localparam int MAX_JOBS_DEF   = 16;
    localparam int MAX_BURSTS_DEF = 4;
    localparam int TIME_BITS_DEF  = 24;

    // transaction field widths
    localparam int JOB_W    = 4;
    localparam int BIDX_W   = 2;
    localparam int FTIME_W  = 24;
    localparam int TDATA_W  = 56;
    localparam int STAMP_W  = 16;

    // input tdata layout
    localparam int IN_JOB_LSB  = 0;
    localparam int IN_BIDX_LSB = 4;
    localparam int IN_ARR_LSB  = 6;
    localparam int IN_BT_LSB   = 30;

    // configuration registers
    localparam int ITER_W     = 3;
    localparam int JCFG_W     = 5;
    localparam int GAP_W      = 16;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_ITERATION_COUNT = 2'd0;
    localparam reg_idx_t REG_JOB_COUNT       = 2'd1;
    localparam reg_idx_t REG_IO_GAP          = 2'd2;

    localparam logic [ITER_W-1:0] ITER_RST = 3'd2;
    localparam logic [JCFG_W-1:0] JOBS_RST = 5'd1;
    localparam logic [GAP_W-1:0]  GAP_RST  = 16'd32;

    localparam logic FUNC_LOAD     = 1'b0;
    localparam logic FUNC_DISPATCH = 1'b1;

    typedef struct packed {
        logic take;
        logic load_wr;
        logic scan_start;
        logic scan_step;
        logic fin;
        logic upd;
        logic out_wr;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } dp_stat_t;

endpackage

### rtl/core/sjf_burst_scheduler.sv
// Non-preemptive shortest-job-first burst scheduler, top level.
// Load transaction: writes the tables, then registers a result before the next one is taken.
// Dispatch: N = job_count clamped to 1..MAX_JOBS slots, scanned one slot per cycle through
// one compare stage and one read port per table; next one taken once its result is registered.
// Synchronous active-low reset: registers to defaults, no job pending, time and stamps zero.
// Depends on sjfbs_pkg, sjfbs_regs, sjfbs_ctrl, sjfbs_dp.
module sjf_burst_scheduler #(
    parameter int MAX_JOBS   = sjfbs_pkg::MAX_JOBS_DEF,
    parameter int MAX_BURSTS = sjfbs_pkg::MAX_BURSTS_DEF,
    parameter int TIME_BITS  = sjfbs_pkg::TIME_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // job[3:0], burst_index[5:4], arrival_time[29:6], burst_time[53:30], zero[55:54]
    input  logic [sjfbs_pkg::TDATA_W-1:0]      s_tdata,
    // func[0]
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // chosen_job[3:0], chosen_burst[5:4], start_time[29:6], finish_time[53:30], zero[55:54]
    output logic [sjfbs_pkg::TDATA_W-1:0]      m_tdata,
    // dispatched[0], all_done[1]
    output logic [1:0]                         m_tuser,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sjfbs_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [sjfbs_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [sjfbs_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                               pready
);

    logic [sjfbs_pkg::ITER_W-1:0] iteration_count;
    logic [sjfbs_pkg::JCFG_W-1:0] job_count;
    logic [sjfbs_pkg::GAP_W-1:0]  io_gap;
    sjfbs_pkg::dp_cmd_t           cmd;
    sjfbs_pkg::dp_stat_t          stat;

    sjfbs_regs u_regs (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .iteration_count (iteration_count),
        .job_count       (job_count),
        .io_gap          (io_gap)
    );

    sjfbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sjfbs_dp #(
        .MAX_JOBS   (MAX_JOBS),
        .MAX_BURSTS (MAX_BURSTS),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_tdata         (s_tdata),
        .iteration_count (iteration_count),
        .job_count       (job_count),
        .io_gap          (io_gap),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser)
    );

endmodule

### rtl/core/sjfbs_regs.sv
// APB-style configuration registers: iteration_count, job_count, io_gap.
// Depends on sjfbs_pkg.
module sjfbs_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sjfbs_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [sjfbs_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [sjfbs_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                               pready,
    output logic [sjfbs_pkg::ITER_W-1:0]       iteration_count,
    output logic [sjfbs_pkg::JCFG_W-1:0]       job_count,
    output logic [sjfbs_pkg::GAP_W-1:0]        io_gap
);

    logic [sjfbs_pkg::ITER_W-1:0] iter_reg;
    logic [sjfbs_pkg::JCFG_W-1:0] jobs_reg;
    logic [sjfbs_pkg::GAP_W-1:0]  gap_reg;
    sjfbs_pkg::reg_idx_t          idx;
    logic                         wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iter_reg <= sjfbs_pkg::ITER_RST;
            jobs_reg <= sjfbs_pkg::JOBS_RST;
            gap_reg  <= sjfbs_pkg::GAP_RST;
        end else if (wr_en) begin
            case (idx)
                sjfbs_pkg::REG_ITERATION_COUNT: iter_reg <= pwdata[sjfbs_pkg::ITER_W-1:0];
                sjfbs_pkg::REG_JOB_COUNT:       jobs_reg <= pwdata[sjfbs_pkg::JCFG_W-1:0];
                sjfbs_pkg::REG_IO_GAP:          gap_reg  <= pwdata[sjfbs_pkg::GAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            sjfbs_pkg::REG_ITERATION_COUNT: prdata = sjfbs_pkg::CFG_DATA_W'(iter_reg);
            sjfbs_pkg::REG_JOB_COUNT:       prdata = sjfbs_pkg::CFG_DATA_W'(jobs_reg);
            sjfbs_pkg::REG_IO_GAP:          prdata = sjfbs_pkg::CFG_DATA_W'(gap_reg);
            default:                        prdata = '0;
        endcase
    end

    assign iteration_count = iter_reg;
    assign job_count       = jobs_reg;
    assign io_gap          = gap_reg;

endmodule

### rtl/core/sjfbs_ctrl.sv
// Controller state machine: sequences load, slot scan, dispatch and output.
// Depends on sjfbs_pkg; drives the datapath through dp_cmd_t.
module sjfbs_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tuser,
    output logic                  s_tready,
    input  sjfbs_pkg::dp_stat_t   stat,
    output sjfbs_pkg::dp_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_UPD   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.take = 1'b1;
                    if (s_tuser == sjfbs_pkg::FUNC_DISPATCH) begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end else begin
                        state_next = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                cmd.load_wr = 1'b1;
                state_next  = S_DONE;
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: state_next = S_FIN;
            S_FIN: begin
                cmd.fin    = 1'b1;
                state_next = S_UPD;
            end
            S_UPD: begin
                cmd.upd    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.out_wr = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath writes never overlap
    a_cmd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.take, cmd.load_wr, cmd.scan_step, cmd.fin, cmd.upd, cmd.out_wr}))
        else $error("overlapping datapath commands");

endmodule

### rtl/core/sjfbs_dp.sv
// Datapath: job tables, one-slot-per-cycle selection, time keeping, output register.
// Depends on sjfbs_pkg; commanded by sjfbs_ctrl.
module sjfbs_dp #(
    parameter int MAX_JOBS   = sjfbs_pkg::MAX_JOBS_DEF,
    parameter int MAX_BURSTS = sjfbs_pkg::MAX_BURSTS_DEF,
    parameter int TIME_BITS  = sjfbs_pkg::TIME_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  sjfbs_pkg::dp_cmd_t                cmd,
    output sjfbs_pkg::dp_stat_t               stat,
    input  logic [sjfbs_pkg::TDATA_W-1:0]     s_tdata,
    input  logic [sjfbs_pkg::ITER_W-1:0]      iteration_count,
    input  logic [sjfbs_pkg::JCFG_W-1:0]      job_count,
    input  logic [sjfbs_pkg::GAP_W-1:0]       io_gap,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sjfbs_pkg::TDATA_W-1:0]     m_tdata,
    output logic [1:0]                        m_tuser
);

    localparam int JIDX_W  = $clog2(MAX_JOBS);
    localparam int JCNT_W  = $clog2(MAX_JOBS + 1);
    localparam int NB_W    = $clog2(MAX_BURSTS + 1);
    localparam int BLEN_D  = MAX_JOBS * MAX_BURSTS;
    localparam int BA_W    = $clog2(BLEN_D);
    localparam int JEXT_W  = (JIDX_W > sjfbs_pkg::JOB_W) ? JIDX_W : sjfbs_pkg::JOB_W;
    localparam int SW      = sjfbs_pkg::STAMP_W;

    typedef logic [TIME_BITS-1:0] time_t;

    // clamped configuration
    logic [NB_W-1:0]   iters;
    logic [JCNT_W-1:0] jobs_used;

    always_comb begin
        if (iteration_count == '0) begin
            iters = NB_W'(1);
        end else if (8'(iteration_count) > 8'(MAX_BURSTS)) begin
            iters = NB_W'(MAX_BURSTS);
        end else begin
            iters = NB_W'(iteration_count);
        end
        if (job_count == '0) begin
            jobs_used = JCNT_W'(1);
        end else if (8'(job_count) > 8'(MAX_JOBS)) begin
            jobs_used = JCNT_W'(MAX_JOBS);
        end else begin
            jobs_used = JCNT_W'(job_count);
        end
    end

    // captured transaction
    logic [sjfbs_pkg::JOB_W-1:0]  job_reg;
    logic [sjfbs_pkg::BIDX_W-1:0] bidx_reg;
    time_t                        arr_reg, bt_reg;

    // state
    time_t                  cur_time_reg;
    logic [SW-1:0]          stamp_cnt_reg;
    logic [NB_W-1:0]        nb_reg [MAX_JOBS];
    time_t                  ready_mem [MAX_JOBS];
    logic [SW-1:0]          stamp_mem [MAX_JOBS];
    time_t                  blen_mem [BLEN_D];

    // scan
    logic [JIDX_W-1:0]      idx_reg;
    logic                   rd_valid_reg, rd_pend_reg;
    logic [JIDX_W-1:0]      rd_idx_reg;
    logic [NB_W-1:0]        rd_nb_reg;
    time_t                  rd_ready_reg, rd_len_reg;
    logic [SW-1:0]          rd_stamp_reg;

    logic                   have_r_reg, have_w_reg;
    logic [JIDX_W-1:0]      r_sel_reg, w_sel_reg;
    logic [NB_W-1:0]        r_nb_reg, w_nb_reg;
    time_t                  r_len_reg, w_len_reg, r_ready_reg, w_ready_reg;
    logic [SW-1:0]          r_age_reg, w_age_reg;

    // dispatch
    logic                   found_reg;
    logic [JIDX_W-1:0]      sel_reg;
    logic [NB_W-1:0]        sel_nb_reg;
    time_t                  start_reg, fin_reg;

    logic                         out_valid_reg;
    logic [sjfbs_pkg::TDATA_W-1:0] out_data_reg;
    logic [1:0]                   out_user_reg;

    // pending flags for every slot
    logic [MAX_JOBS-1:0] pend_vec;
    for (genvar g = 0; g < MAX_JOBS; g++) begin : g_pend
        assign pend_vec[g] = (8'(g) < 8'(jobs_used)) && (nb_reg[g] < iters);
    end

    // load decode
    logic [JEXT_W-1:0] job_ext;
    logic [JIDX_W-1:0] job_idx;
    logic              load_ok, load_first;
    assign job_ext    = JEXT_W'(job_reg);
    assign job_idx    = job_ext[JIDX_W-1:0];
    assign load_ok    = (8'(job_reg) < 8'(jobs_used)) && (8'(bidx_reg) < 8'(MAX_BURSTS));
    assign load_first = load_ok && (bidx_reg == '0);

    // re-queue decision
    logic [NB_W-1:0] nb_inc;
    logic            more;
    logic [TIME_BITS:0] gap_sum;
    time_t           requeue_time;
    assign nb_inc       = NB_W'(sel_nb_reg + NB_W'(1));
    assign more         = found_reg && (nb_inc < iters);
    assign gap_sum      = {1'b0, fin_reg} + {1'b0, TIME_BITS'(io_gap)};
    assign requeue_time = gap_sum[TIME_BITS] ? '1 : gap_sum[TIME_BITS-1:0];

    // shared write port of ready/stamp tables
    logic              tab_we;
    logic [JIDX_W-1:0] tab_wa;
    time_t             tab_wd;
    always_comb begin
        tab_we = 1'b0;
        tab_wa = job_idx;
        tab_wd = arr_reg;
        if (cmd.load_wr && load_first) begin
            tab_we = 1'b1;
        end else if (cmd.upd && more) begin
            tab_we = 1'b1;
            tab_wa = sel_reg;
            tab_wd = requeue_time;
        end
    end

    logic [BA_W-1:0] blen_wa, blen_ra;
    assign blen_wa = BA_W'(32'(job_idx) * 32'(MAX_BURSTS) + 32'(bidx_reg));
    assign blen_ra = BA_W'(32'(idx_reg) * 32'(MAX_BURSTS) + 32'(nb_reg[idx_reg]));

    always_ff @(posedge aclk) begin
        if (tab_we) begin
            ready_mem[tab_wa] <= tab_wd;
            stamp_mem[tab_wa] <= stamp_cnt_reg;
        end
        rd_ready_reg <= ready_mem[idx_reg];
        rd_stamp_reg <= stamp_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_wr && load_ok) begin
            blen_mem[blen_wa] <= bt_reg;
        end
        rd_len_reg <= blen_mem[blen_ra];
    end

    // compare stage
    logic [SW-1:0] age_j;
    logic          is_ready, r_after, w_after, take_r, take_w;
    always_comb begin
        age_j    = SW'(stamp_cnt_reg - rd_stamp_reg);
        is_ready = rd_ready_reg <= cur_time_reg;
        r_after  = (rd_ready_reg != r_ready_reg) ? (rd_ready_reg > r_ready_reg)
                                                 : (age_j < r_age_reg);
        w_after  = (w_ready_reg != rd_ready_reg) ? (w_ready_reg > rd_ready_reg)
                                                 : (w_age_reg < age_j);
        take_r   = rd_valid_reg && rd_pend_reg && is_ready &&
                   (!have_r_reg || (rd_len_reg < r_len_reg) ||
                    ((rd_len_reg == r_len_reg) && r_after));
        take_w   = rd_valid_reg && rd_pend_reg && !is_ready && (!have_w_reg || w_after);
    end

    // dispatch times
    time_t              d_start, d_len;
    logic [TIME_BITS:0] d_sum;
    always_comb begin
        d_start = have_r_reg ? cur_time_reg : w_ready_reg;
        d_len   = have_r_reg ? r_len_reg : w_len_reg;
        d_sum   = {1'b0, d_start} + {1'b0, d_len};
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            job_reg  <= s_tdata[sjfbs_pkg::IN_JOB_LSB +: sjfbs_pkg::JOB_W];
            bidx_reg <= s_tdata[sjfbs_pkg::IN_BIDX_LSB +: sjfbs_pkg::BIDX_W];
            arr_reg  <= TIME_BITS'(s_tdata[sjfbs_pkg::IN_ARR_LSB +: sjfbs_pkg::FTIME_W]);
            bt_reg   <= TIME_BITS'(s_tdata[sjfbs_pkg::IN_BT_LSB +: sjfbs_pkg::FTIME_W]);
        end
        rd_idx_reg  <= idx_reg;
        rd_nb_reg   <= nb_reg[idx_reg];
        rd_pend_reg <= pend_vec[idx_reg];
        if (take_r) begin
            r_sel_reg   <= rd_idx_reg;
            r_nb_reg    <= rd_nb_reg;
            r_len_reg   <= rd_len_reg;
            r_ready_reg <= rd_ready_reg;
            r_age_reg   <= age_j;
        end
        if (take_w) begin
            w_sel_reg   <= rd_idx_reg;
            w_nb_reg    <= rd_nb_reg;
            w_len_reg   <= rd_len_reg;
            w_ready_reg <= rd_ready_reg;
            w_age_reg   <= age_j;
        end
        if (cmd.fin) begin
            sel_reg    <= have_r_reg ? r_sel_reg : w_sel_reg;
            sel_nb_reg <= have_r_reg ? r_nb_reg : w_nb_reg;
            start_reg  <= d_start;
            fin_reg    <= d_sum[TIME_BITS] ? '1 : d_sum[TIME_BITS-1:0];
        end
        if (cmd.out_wr) begin
            out_user_reg <= {~|pend_vec, found_reg};
            out_data_reg <= found_reg ?
                {2'b00, sjfbs_pkg::FTIME_W'(fin_reg), sjfbs_pkg::FTIME_W'(start_reg),
                 sjfbs_pkg::BIDX_W'(sel_nb_reg), sjfbs_pkg::JOB_W'(sel_reg)} : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_time_reg  <= '0;
            stamp_cnt_reg <= '0;
            idx_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            have_r_reg    <= 1'b0;
            have_w_reg    <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_JOBS; i++) begin
                nb_reg[i] <= NB_W'(MAX_BURSTS);
            end
        end else begin
            rd_valid_reg <= cmd.scan_step;
            if (cmd.scan_start) begin
                idx_reg    <= '0;
                have_r_reg <= 1'b0;
                have_w_reg <= 1'b0;
            end else begin
                if (cmd.scan_step) begin
                    idx_reg <= JIDX_W'(idx_reg + JIDX_W'(1));
                end
                if (take_r) begin
                    have_r_reg <= 1'b1;
                end
                if (take_w) begin
                    have_w_reg <= 1'b1;
                end
            end
            if (cmd.take) begin
                found_reg <= 1'b0;
            end else if (cmd.fin) begin
                found_reg <= have_r_reg | have_w_reg;
            end
            if (cmd.load_wr && load_first) begin
                nb_reg[job_idx] <= '0;
                stamp_cnt_reg   <= SW'(stamp_cnt_reg + SW'(1));
            end
            if (cmd.upd && found_reg) begin
                cur_time_reg <= fin_reg;
                if (more) begin
                    nb_reg[sel_reg] <= nb_inc;
                    stamp_cnt_reg   <= SW'(stamp_cnt_reg + SW'(1));
                end else begin
                    nb_reg[sel_reg] <= NB_W'(MAX_BURSTS);
                end
            end
            if (cmd.out_wr) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.scan_last = (idx_reg == JIDX_W'(jobs_used - JCNT_W'(1)));
    assign stat.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    a_sel_in_use: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_wr && found_reg |-> 8'(sel_reg) < 8'(jobs_used))
        else $error("dispatched slot outside jobs in use");

    a_fin_after_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin |=> (!found_reg || fin_reg >= start_reg))
        else $error("finish before start");

    a_ready_pick: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin && have_r_reg |-> r_ready_reg <= cur_time_reg)
        else $error("picked job not ready");

    a_stamp_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(stamp_cnt_reg) |-> stamp_cnt_reg == SW'($past(stamp_cnt_reg) + SW'(1)))
        else $error("stamp counter jumped");

endmodule

### test/tb_top.sv
// Self-checking testbench for sjf_burst_scheduler: a directed table, then random load and dispatch
// traffic with random idling, APB register writes with read-back, and a behavioural scheduler model.
// Depends on sjfbs_pkg and the sjf_burst_scheduler RTL.
module tb_top;

    localparam int NJOBS         = 16;
    localparam int NBURSTS       = 4;
    localparam logic [23:0] TIME_MAX = 24'hFFFFFF;
    localparam int IDLE_LIMIT    = 5000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 30;

    typedef struct packed {
        logic        dispatched;
        logic        all_done;
        logic [3:0]  job;
        logic [1:0]  burst;
        logic [23:0] start;
        logic [23:0] finish;
    } sched_res_t;

    typedef struct {
        bit                   is_cfg;
        sjfbs_pkg::reg_idx_t  reg_sel;
        logic [31:0]          reg_val;
        logic                 func;
        logic [3:0]           job;
        logic [1:0]           bidx;
        logic [23:0]          arr;
        logic [23:0]          bt;
        bit                   typed;
        sched_res_t           res;
    } plan_row_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [sjfbs_pkg::TDATA_W-1:0]    s_tdata;
    logic                             s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [sjfbs_pkg::TDATA_W-1:0]    m_tdata;
    logic [1:0]                       m_tuser;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [sjfbs_pkg::CFG_ADDR_W-1:0] paddr;
    logic [sjfbs_pkg::CFG_DATA_W-1:0] pwdata;
    logic [sjfbs_pkg::CFG_DATA_W-1:0] prdata;
    logic                             pready;

    sjf_burst_scheduler DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // scheduler model state
    logic [2:0]  cfg_iters;
    logic [4:0]  cfg_jobs;
    logic [15:0] cfg_gap;
    logic [23:0] job_ready [NJOBS];
    logic [23:0] burst_len [NJOBS][NBURSTS];
    bit          burst_set [NJOBS][NBURSTS];
    logic [2:0]  job_next  [NJOBS];
    logic [15:0] job_stamp [NJOBS];
    logic [15:0] stamp_ctr;
    logic [23:0] sched_now;

    sched_res_t outcome_q[$];
    plan_row_t  plan[$];

    int  errors;
    int  n_loads;
    int  n_disp_req;
    int  n_results;
    int  n_dispatched;
    int  n_reg_writes;
    int  n_random;
    bit  fast_send;
    bit  fast_recv;
    bit  hold_req;
    bit  hold_done;

    function automatic int iters_eff();
        if (cfg_iters == 3'd0) return 1;
        if (int'(cfg_iters) > NBURSTS) return NBURSTS;
        return int'(cfg_iters);
    endfunction

    function automatic int jobs_eff();
        if (cfg_jobs == 5'd0) return 1;
        if (int'(cfg_jobs) > NJOBS) return NJOBS;
        return int'(cfg_jobs);
    endfunction

    function automatic bit job_waiting(int j);
        return j < jobs_eff() && int'(job_next[j]) < iters_eff();
    endfunction

    function automatic bit any_waiting();
        for (int j = 0; j < NJOBS; j++)
            if (job_waiting(j)) return 1'b1;
        return 1'b0;
    endfunction

    // a stands behind b: later ready time, else younger stamp
    function automatic bit queued_after(int a, int b);
        logic [15:0] age_a;
        logic [15:0] age_b;
        if (job_ready[a] != job_ready[b]) return job_ready[a] > job_ready[b];
        age_a = stamp_ctr - job_stamp[a];
        age_b = stamp_ctr - job_stamp[b];
        return age_a < age_b;
    endfunction

    function automatic logic [23:0] sat_sum(logic [23:0] a, logic [23:0] b);
        logic [24:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[24] ? TIME_MAX : s[23:0];
    endfunction

    function automatic void stamp_job(int j);
        job_stamp[j] = stamp_ctr;
        stamp_ctr = stamp_ctr + 16'd1;
    endfunction

    function automatic sched_res_t schedule_item(logic func, logic [3:0] job, logic [1:0] bidx,
                                                 logic [23:0] arr, logic [23:0] bt);
        sched_res_t  r;
        bit          have_rdy;
        bit          have_wait;
        int          rsel;
        int          wsel;
        int          sel;
        logic [23:0] best;
        logic [23:0] len;
        r = '0;
        have_rdy = 1'b0;
        have_wait = 1'b0;
        rsel = 0;
        wsel = 0;
        best = '0;
        if (func == sjfbs_pkg::FUNC_LOAD) begin
            if (int'(job) < jobs_eff()) begin
                burst_len[job][bidx] = bt;
                burst_set[job][bidx] = 1'b1;
                if (bidx == 2'd0) begin
                    job_ready[job] = arr;
                    job_next[job] = 3'd0;
                    stamp_job(int'(job));
                end
            end
        end else begin
            for (int j = 0; j < jobs_eff(); j++) begin
                if (job_waiting(j)) begin
                    len = burst_len[j][job_next[j]];
                    if (job_ready[j] <= sched_now) begin
                        if (!have_rdy || len < best || (len == best && queued_after(j, rsel))) begin
                            rsel = j;
                            best = len;
                            have_rdy = 1'b1;
                        end
                    end else if (!have_wait || queued_after(wsel, j)) begin
                        wsel = j;
                        have_wait = 1'b1;
                    end
                end
            end
            if (have_rdy || have_wait) begin
                sel = have_rdy ? rsel : wsel;
                if (!have_rdy) sched_now = job_ready[sel];
                r.dispatched = 1'b1;
                r.job = sel[3:0];
                r.burst = job_next[sel][1:0];
                r.start = sched_now;
                r.finish = sat_sum(sched_now, burst_len[sel][job_next[sel]]);
                sched_now = r.finish;
                if (int'(job_next[sel]) + 1 < iters_eff()) begin
                    job_next[sel] = job_next[sel] + 3'd1;
                    job_ready[sel] = sat_sum(r.finish, {8'd0, cfg_gap});
                    stamp_job(sel);
                end else begin
                    job_next[sel] = 3'(NBURSTS);
                end
            end
        end
        r.all_done = !any_waiting();
        return r;
    endfunction

    function automatic sched_res_t outcome(logic d, logic done, int cj, int cb,
                                           logic [23:0] st, logic [23:0] fi);
        sched_res_t r;
        r.dispatched = d;
        r.all_done = done;
        r.job = 4'(cj);
        r.burst = 2'(cb);
        r.start = st;
        r.finish = fi;
        return r;
    endfunction

    function automatic plan_row_t item_row(logic func, int job, int bidx,
                                           logic [23:0] arr, logic [23:0] bt);
        plan_row_t r;
        r.is_cfg = 1'b0;
        r.reg_sel = sjfbs_pkg::REG_ITERATION_COUNT;
        r.reg_val = '0;
        r.func = func;
        r.job = 4'(job);
        r.bidx = 2'(bidx);
        r.arr = arr;
        r.bt = bt;
        r.typed = 1'b0;
        r.res = '0;
        return r;
    endfunction

    function automatic plan_row_t typed_row(logic func, int job, int bidx, logic [23:0] arr,
                                            logic [23:0] bt, sched_res_t res);
        plan_row_t r;
        r = item_row(func, job, bidx, arr, bt);
        r.typed = 1'b1;
        r.res = res;
        return r;
    endfunction

    function automatic plan_row_t cfg_row(sjfbs_pkg::reg_idx_t idx, logic [31:0] v);
        plan_row_t r;
        r = item_row(sjfbs_pkg::FUNC_LOAD, 0, 0, '0, '0);
        r.is_cfg = 1'b1;
        r.reg_sel = idx;
        r.reg_val = v;
        return r;
    endfunction

    function automatic void check_field(string name, logic [23:0] want_v, logic [23:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want_v, got_v);
            errors++;
        end
    endfunction

    function automatic logic [23:0] pick_len(bit wide);
        return wide ? 24'($urandom) : 24'($urandom_range(0, 300));
    endfunction

    function automatic logic [23:0] pick_arrival(bit wide);
        logic [23:0] a;
        if (wide) a = 24'($urandom);
        else if ($urandom_range(0, 3) == 0) a = 24'($urandom_range(0, sched_now));
        else a = sat_sum(sched_now, 24'($urandom_range(0, 400)));
        return a;
    endfunction

    task automatic send_item(logic func, logic [3:0] job, logic [1:0] bidx, logic [23:0] arr,
                             logic [23:0] bt, bit typed, sched_res_t typed_res);
        int         gap;
        sched_res_t r;
        if ($urandom_range(0, 49) == 0) fast_send = !fast_send;
        gap = fast_send ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = func;
        s_tdata = {2'b00, bt, arr, bidx, job};
        do @(posedge aclk); while (!s_tready);
        r = schedule_item(func, job, bidx, arr, bt);
        outcome_q.push_back(typed ? typed_res : r);
        if (func == sjfbs_pkg::FUNC_LOAD) n_loads++;
        else n_disp_req++;
        @(negedge aclk);
    endtask

    task automatic send_load(int j, int b, logic [23:0] arr, logic [23:0] bt);
        send_item(sjfbs_pkg::FUNC_LOAD, 4'(j), 2'(b), arr, bt, 1'b0, '0);
    endtask

    task automatic send_dispatch();
        send_item(sjfbs_pkg::FUNC_DISPATCH, 4'($urandom), 2'($urandom), 24'($urandom),
                  24'($urandom), 1'b0, '0);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (outcome_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic apb_access(bit wr, sjfbs_pkg::reg_idx_t idx, logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = wr;
        paddr = {idx, 2'b00};
        pwdata = wdata;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic write_reg(sjfbs_pkg::reg_idx_t idx, logic [31:0] v);
        logic [31:0] rd;
        logic [31:0] want;
        drain();
        apb_access(1'b1, idx, v, rd);
        case (idx)
            sjfbs_pkg::REG_ITERATION_COUNT: begin
                cfg_iters = v[sjfbs_pkg::ITER_W-1:0];
                want = 32'(cfg_iters);
            end
            sjfbs_pkg::REG_JOB_COUNT: begin
                cfg_jobs = v[sjfbs_pkg::JCFG_W-1:0];
                want = 32'(cfg_jobs);
            end
            default: begin
                cfg_gap = v[sjfbs_pkg::GAP_W-1:0];
                want = 32'(cfg_gap);
            end
        endcase
        n_reg_writes++;
        apb_access(1'b0, idx, '0, rd);
        if (rd !== want) begin
            $display("%0t: register %0d read-back: expected %0h, got %0h", $time, idx, want, rd);
            errors++;
        end
    endtask

    task automatic set_config(int iters, int jobs, int gap);
        write_reg(sjfbs_pkg::REG_ITERATION_COUNT, 32'(iters));
        write_reg(sjfbs_pkg::REG_JOB_COUNT, 32'(jobs));
        write_reg(sjfbs_pkg::REG_IO_GAP, 32'(gap));
    endtask

    // Mostly complete job loads and dispatch requests; some length rewrites and
    // loads to slots outside job_count, which the block ignores.
    task automatic run_phase(int n_items, bit wide);
        int done_items;
        int pick;
        int j;
        done_items = 0;
        while (done_items < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                j = $urandom_range(0, jobs_eff() - 1);
                for (int b = NBURSTS - 1; b > 0; b--) begin
                    if (!burst_set[j][b] || $urandom_range(0, 1) == 1) begin
                        send_load(j, b, 24'($urandom), pick_len(wide));
                        done_items++;
                    end
                end
                send_load(j, 0, pick_arrival(wide), pick_len(wide));
                done_items++;
            end else if (pick < 85) begin
                send_dispatch();
                done_items++;
            end else if (pick < 93) begin
                j = $urandom_range(0, jobs_eff() - 1);
                send_load(j, $urandom_range(1, NBURSTS - 1), 24'($urandom), pick_len(wide));
                done_items++;
            end else if (jobs_eff() < NJOBS) begin
                j = $urandom_range(jobs_eff(), NJOBS - 1);
                send_load(j, $urandom_range(0, NBURSTS - 1), 24'($urandom), 24'($urandom));
            end else begin
                send_dispatch();
                done_items++;
            end
            if (!hold_done && n_random + done_items > 300) begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
        end
        n_random += done_items;
    endtask

    initial begin : stimulus
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        n_loads = 0;
        n_disp_req = 0;
        n_results = 0;
        n_dispatched = 0;
        n_reg_writes = 0;
        n_random = 0;
        fast_send = 1'b0;
        fast_recv = 1'b0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        cfg_iters = sjfbs_pkg::ITER_RST;
        cfg_jobs = sjfbs_pkg::JOBS_RST;
        cfg_gap = sjfbs_pkg::GAP_RST;
        stamp_ctr = '0;
        sched_now = '0;
        for (int j = 0; j < NJOBS; j++) begin
            job_ready[j] = '0;
            job_next[j] = 3'(NBURSTS);
            job_stamp[j] = '0;
            for (int b = 0; b < NBURSTS; b++) begin
                burst_len[j][b] = '0;
                burst_set[j][b] = 1'b0;
            end
        end

        // defaults: two bursts, one job, gap of 32
        plan.push_back(typed_row(sjfbs_pkg::FUNC_DISPATCH, 0, 0, 0, 0,
                                 outcome(0, 1, 0, 0, 0, 0)));
        plan.push_back(typed_row(sjfbs_pkg::FUNC_LOAD, 5, 3, TIME_MAX, TIME_MAX,
                                 outcome(0, 1, 0, 0, 0, 0)));
        plan.push_back(typed_row(sjfbs_pkg::FUNC_LOAD, 0, 1, 0, 5, outcome(0, 1, 0, 0, 0, 0)));
        plan.push_back(typed_row(sjfbs_pkg::FUNC_LOAD, 0, 0, 0, 3, outcome(0, 0, 0, 0, 0, 0)));
        plan.push_back(typed_row(sjfbs_pkg::FUNC_DISPATCH, 0, 0, 0, 0,
                                 outcome(1, 0, 0, 0, 0, 3)));
        plan.push_back(typed_row(sjfbs_pkg::FUNC_DISPATCH, 0, 0, 0, 0,
                                 outcome(1, 1, 0, 1, 35, 40)));
        plan.push_back(typed_row(sjfbs_pkg::FUNC_DISPATCH, 0, 0, 0, 0,
                                 outcome(0, 1, 0, 0, 0, 0)));
        plan.push_back(cfg_row(sjfbs_pkg::REG_ITERATION_COUNT, 2));
        plan.push_back(cfg_row(sjfbs_pkg::REG_JOB_COUNT, 16));
        plan.push_back(cfg_row(sjfbs_pkg::REG_IO_GAP, 0));
        // equal lengths and ready times: later insertion wins; job 3 arrives late
        plan.push_back(item_row(sjfbs_pkg::FUNC_LOAD, 1, 1, 0, 7));
        plan.push_back(item_row(sjfbs_pkg::FUNC_LOAD, 1, 0, 40, 10));
        plan.push_back(item_row(sjfbs_pkg::FUNC_LOAD, 2, 1, 0, 7));
        plan.push_back(item_row(sjfbs_pkg::FUNC_LOAD, 2, 0, 40, 10));
        plan.push_back(item_row(sjfbs_pkg::FUNC_LOAD, 3, 1, 0, 2));
        plan.push_back(item_row(sjfbs_pkg::FUNC_LOAD, 3, 0, 100, 1));
        plan.push_back(item_row(sjfbs_pkg::FUNC_LOAD, 15, 2, TIME_MAX, TIME_MAX));
        repeat (6) plan.push_back(item_row(sjfbs_pkg::FUNC_DISPATCH, 0, 0, 0, 0));
        // restart of a running job, zero-length bursts
        plan.push_back(item_row(sjfbs_pkg::FUNC_LOAD, 3, 0, 5, 4));
        plan.push_back(item_row(sjfbs_pkg::FUNC_DISPATCH, 0, 0, 0, 0));
        plan.push_back(item_row(sjfbs_pkg::FUNC_LOAD, 3, 0, 0, 0));
        plan.push_back(item_row(sjfbs_pkg::FUNC_DISPATCH, 0, 0, 0, 0));
        plan.push_back(item_row(sjfbs_pkg::FUNC_DISPATCH, 0, 0, 0, 0));

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                write_reg(plan[i].reg_sel, plan[i].reg_val);
            end else begin
                send_item(plan[i].func, plan[i].job, plan[i].bidx, plan[i].arr, plan[i].bt,
                          plan[i].typed, plan[i].res);
            end
        end

        set_config(4, 16, 16);
        run_phase(120, 1'b0);
        set_config(1, 4, 0);
        run_phase(120, 1'b0);
        set_config(0, 0, 65535);
        run_phase(110, 1'b0);
        set_config(7, 31, 100);
        run_phase(120, 1'b0);
        set_config(3, 8, 5);
        run_phase(120, 1'b0);
        set_config(2, 16, 0);
        run_phase(120, 1'b0);
        set_config(4, 2, 65535);
        run_phase(100, 1'b0);
        set_config(3, 16, 40);
        run_phase(120, 1'b0);
        // full-range times: saturating clock from here on
        set_config(4, 16, 65535);
        run_phase(100, 1'b1);

        s_tvalid = 1'b0;
        while (outcome_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Covered %0d loads and %0d dispatch requests (%0d random), %0d register writes.",
                 n_loads, n_disp_req, n_random, n_reg_writes);
        $display("Checked %0d results, %0d of them dispatched bursts.", n_results, n_dispatched);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : result_sink
        sched_res_t want;
        sched_res_t got;
        int         stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            if ($urandom_range(0, 49) == 0) fast_recv = !fast_recv;
            stall = fast_recv ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.dispatched = m_tuser[0];
            got.all_done = m_tuser[1];
            got.job = m_tdata[3:0];
            got.burst = m_tdata[5:4];
            got.start = m_tdata[29:6];
            got.finish = m_tdata[53:30];
            n_results++;
            if (got.dispatched === 1'b1) n_dispatched++;
            if (outcome_q.size() == 0) begin
                $display("%0t: result with none expected: tuser %0h tdata %0h",
                         $time, m_tuser, m_tdata);
                errors++;
            end else begin
                want = outcome_q.pop_front();
                check_field("dispatched", 24'(want.dispatched), 24'(got.dispatched));
                check_field("all_done", 24'(want.all_done), 24'(got.all_done));
                check_field("chosen_job", 24'(want.job), 24'(got.job));
                check_field("chosen_burst", 24'(want.burst), 24'(got.burst));
                check_field("start_time", want.start, got.start);
                check_field("finish_time", want.finish, got.finish);
            end
            @(negedge aclk);
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle = 0;
            else idle++;
        end
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, IDLE_LIMIT, outcome_q.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
